FILE: sv/rcm_pkg.sv
package rcm_pkg;

  localparam int GRID_DIM   = 64;
  localparam int MAX_LAYERS = 4;

  localparam int GRID_W  = $clog2(GRID_DIM);
  localparam int LAYER_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int ADDR_W  = LAYER_W + 2 * GRID_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int CNT_W   = ADDR_W + 1;
  localparam int EL_W    = $clog2(MAX_LAYERS + 1);

  localparam int COORD_W = 16;
  localparam int UTIL_W  = 32;
  // snapped box side in coordinate units, and the weighted numerator
  localparam int SIDE_W  = GRID_W + 1 + COORD_W;
  localparam int NP_W    = COORD_W + SIDE_W + 1;
  localparam int NUM_W   = NP_W + 8;
  localparam int SUM_W   = UTIL_W + ADDR_W;
  localparam int DW      = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int DCNT_W  = $clog2(DW + 1);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] REG_BIN_W  = 2'd0;
  localparam logic [1:0] REG_BIN_H  = 2'd1;
  localparam logic [1:0] REG_LAYERS = 2'd2;

  typedef enum logic [2:0] {
    JOB_LLX,
    JOB_URX,
    JOB_LLY,
    JOB_URY,
    JOB_INC,
    JOB_AVG
  } job_t;

  typedef struct packed {
    logic load;
    logic scan_rst;
    logic clr_wr;
    logic div_start;
    logic div_take;
    job_t job;
    logic box;
    logic mul1;
    logic mul2;
    logic walk_rd;
    logic walk_wr;
    logic scan_rd;
    logic cost;
    logic fire;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       layer_ok;
    logic       div_done;
    logic       clr_last;
    logic       walk_last;
    logic       scan_last;
  } sts_t;

  typedef struct packed {
    logic [GRID_W-1:0] lo;
    logic [GRID_W:0]   hi;
  } span_t;

  // outward snap of one axis, upper index exclusive, never empty
  function automatic span_t snap(input logic [COORD_W-1:0] ql,
                                 input logic [COORD_W-1:0] qu);
    logic [COORD_W:0] u;
    logic [COORD_W:0] l;
    span_t s;
    u = {1'b0, qu} + 1'b1;
    if (int'(u) > GRID_DIM) u = (COORD_W + 1)'(GRID_DIM);
    l = {1'b0, ql};
    if (int'(l) > GRID_DIM - 1) l = (COORD_W + 1)'(GRID_DIM - 1);
    if (l >= u) l = u - 1'b1;
    s.lo = l[GRID_W-1:0];
    s.hi = u[GRID_W:0];
    return s;
  endfunction

endpackage

FILE: sv/rcm_ram.sv
module rcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

FILE: sv/rcm_div.sv
module rcm_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [rcm_pkg::DW-1:0] dividend,
  input  logic [rcm_pkg::DW-1:0] divisor,
  output logic                   done,
  output logic [rcm_pkg::DW-1:0] quotient
);

  logic [rcm_pkg::DW-1:0]     q;
  logic [rcm_pkg::DW-1:0]     r;
  logic [rcm_pkg::DW-1:0]     d;
  logic [rcm_pkg::DCNT_W-1:0] cnt;
  logic                       run;
  logic [rcm_pkg::DW:0]       rs;
  logic                       ge;

  assign rs       = {r, q[rcm_pkg::DW-1]};
  assign ge       = rs >= {1'b0, d};
  assign quotient = q;

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= rcm_pkg::DCNT_W'(rcm_pkg::DW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == rcm_pkg::DCNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (run) begin
      if (ge) r <= rcm_pkg::DW'(rs - {1'b0, d});
      else r <= rs[rcm_pkg::DW-1:0];
      q <= {q[rcm_pkg::DW-2:0], ge};
    end
  end

endmodule

FILE: sv/rcm_ctrl.sv
module rcm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rcm_pkg::sts_t   sts,
  output rcm_pkg::cmd_t   cmd,
  output logic            busy
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CLR   = 13'b0000000000010,
    S_DIV   = 13'b0000000000100,
    S_DIVW  = 13'b0000000001000,
    S_BOX   = 13'b0000000010000,
    S_MUL1  = 13'b0000000100000,
    S_MUL2  = 13'b0000001000000,
    S_WRD   = 13'b0000010000000,
    S_WWR   = 13'b0000100000000,
    S_SCAN  = 13'b0001000000000,
    S_DRAIN = 13'b0010000000000,
    S_COST  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t        state, state_next;
  rcm_pkg::job_t job, job_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      job   <= rcm_pkg::JOB_LLX;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next   = job;
    cmd        = '0;
    cmd.job    = job;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          cmd.scan_rst = 1'b1;
          unique case (sts.opcode)
            rcm_pkg::OP_CLEAR:  state_next = S_CLR;
            rcm_pkg::OP_ADD: begin
              if (sts.layer_ok) begin
                state_next = S_DIV;
                job_next   = rcm_pkg::JOB_LLX;
              end
            end
            rcm_pkg::OP_REPORT: state_next = S_SCAN;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          unique case (job)
            rcm_pkg::JOB_LLX: begin job_next = rcm_pkg::JOB_URX; state_next = S_DIV; end
            rcm_pkg::JOB_URX: begin job_next = rcm_pkg::JOB_LLY; state_next = S_DIV; end
            rcm_pkg::JOB_LLY: begin job_next = rcm_pkg::JOB_URY; state_next = S_DIV; end
            rcm_pkg::JOB_URY: state_next = S_BOX;
            rcm_pkg::JOB_INC: state_next = S_WRD;
            rcm_pkg::JOB_AVG: state_next = S_COST;
            default:          state_next = S_IDLE;
          endcase
        end
      end
      S_BOX: begin
        cmd.box    = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        job_next   = rcm_pkg::JOB_INC;
        state_next = S_DIV;
      end
      S_WRD: begin
        cmd.walk_rd = 1'b1;
        state_next  = S_WWR;
      end
      S_WWR: begin
        cmd.walk_wr = 1'b1;
        state_next  = sts.walk_last ? S_IDLE : S_WRD;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        job_next   = rcm_pkg::JOB_AVG;
        state_next = S_DIV;
      end
      S_COST: begin
        cmd.cost   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.fire   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: sv/rcm_dp.sv
module rcm_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  rcm_pkg::cmd_t                   cmd,
  output rcm_pkg::sts_t                   sts,
  input  logic [15:0]                     bin_width,
  input  logic [15:0]                     bin_height,
  input  logic [2:0]                      layers_in_use,
  input  logic [1:0]                      opcode,
  input  logic [1:0]                      layer,
  input  logic [15:0]                     ll_x,
  input  logic [15:0]                     ll_y,
  input  logic [15:0]                     ur_x,
  input  logic [15:0]                     ur_y,
  input  logic [15:0]                     wire_weight,
  output logic                            done,
  output logic [31:0]                     peak_util,
  output logic [31:0]                     mean_util,
  output logic [31:0]                     cost
);

  localparam int GW = rcm_pkg::GRID_W;
  localparam int DW = rcm_pkg::DW;

  logic [15:0]                   bw, bh;
  logic [rcm_pkg::EL_W-1:0]      eff;
  logic [rcm_pkg::CNT_W-1:0]     count;

  logic [rcm_pkg::LAYER_W-1:0]   lay;
  logic [15:0]                   llx, lly, urx, ury, wgt;
  logic [15:0]                   q_llx, q_urx, q_lly, q_ury;
  logic [GW-1:0]                 xl, yl, wx, wy;
  logic [GW:0]                   xu, yu;
  logic [rcm_pkg::SIDE_W-1:0]    w, h;
  logic [rcm_pkg::NUM_W-1:0]     num;
  logic [2*rcm_pkg::SIDE_W-1:0]  den;
  logic [31:0]                   inc;
  logic [rcm_pkg::SUM_W-1:0]     sum;
  logic [31:0]                   mx, avg;
  logic [63:0]                   prod;
  logic [rcm_pkg::CNT_W-1:0]     scan_cnt;
  logic                          rd_v;
  rcm_pkg::span_t                sx, sy;
  logic [rcm_pkg::NP_W-1:0]      np;

  logic [DW-1:0]                 dvd, dvs, quo;
  logic                          div_done;

  logic                          ram_we;
  logic [rcm_pkg::ADDR_W-1:0]    ram_addr;
  logic [31:0]                   ram_wdata, ram_rdata;
  logic [32:0]                   acc;

  assign bw = (bin_width == '0) ? 16'd1 : bin_width;
  assign bh = (bin_height == '0) ? 16'd1 : bin_height;

  always_comb begin
    if (layers_in_use == '0) eff = rcm_pkg::EL_W'(1);
    else if (int'(layers_in_use) > rcm_pkg::MAX_LAYERS)
      eff = rcm_pkg::EL_W'(rcm_pkg::MAX_LAYERS);
    else eff = rcm_pkg::EL_W'(layers_in_use);
  end

  assign count = rcm_pkg::CNT_W'(eff) << (2 * GW);

  assign sts.opcode    = opcode;
  assign sts.layer_ok  = int'(layer) < int'(eff);
  assign sts.div_done  = div_done;
  assign sts.clr_last  = scan_cnt[rcm_pkg::ADDR_W-1:0] == '1;
  assign sts.walk_last = (wx == GW'(xu - 1'b1)) && (wy == GW'(yu - 1'b1));
  assign sts.scan_last = scan_cnt == count - 1'b1;

  assign sx = rcm_pkg::snap(q_llx, q_urx);
  assign sy = rcm_pkg::snap(q_lly, q_ury);
  assign np = rcm_pkg::NP_W'(wgt) * rcm_pkg::NP_W'({1'b0, w} + {1'b0, h});

  always_comb begin
    unique case (cmd.job)
      rcm_pkg::JOB_LLX: begin dvd = DW'(llx); dvs = DW'(bw); end
      rcm_pkg::JOB_URX: begin dvd = DW'(urx); dvs = DW'(bw); end
      rcm_pkg::JOB_LLY: begin dvd = DW'(lly); dvs = DW'(bh); end
      rcm_pkg::JOB_URY: begin dvd = DW'(ury); dvs = DW'(bh); end
      rcm_pkg::JOB_INC: begin dvd = DW'(num); dvs = DW'(den); end
      rcm_pkg::JOB_AVG: begin dvd = DW'(sum); dvs = DW'(count); end
      default:          begin dvd = DW'(num); dvs = DW'(den); end
    endcase
  end

  rcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  assign acc = {1'b0, ram_rdata} + {1'b0, inc};

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = scan_cnt[rcm_pkg::ADDR_W-1:0];
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.walk_rd || cmd.walk_wr) begin
      ram_addr  = {lay, wx, wy};
      ram_we    = cmd.walk_wr;
      ram_wdata = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
    end
  end

  rcm_ram #(
    .WIDTH (32),
    .DEPTH (rcm_pkg::DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      rd_v     <= 1'b0;
      done     <= 1'b0;
    end else begin
      rd_v <= cmd.scan_rd;
      done <= cmd.fire;
      if (cmd.scan_rst) scan_cnt <= '0;
      else if (cmd.clr_wr || cmd.scan_rd) scan_cnt <= scan_cnt + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lay <= rcm_pkg::LAYER_W'(layer);
      llx <= ll_x;
      lly <= ll_y;
      urx <= ur_x;
      ury <= ur_y;
      wgt <= wire_weight;
    end
    if (cmd.div_take) begin
      unique case (cmd.job)
        rcm_pkg::JOB_LLX: q_llx <= quo[15:0];
        rcm_pkg::JOB_URX: q_urx <= quo[15:0];
        rcm_pkg::JOB_LLY: q_lly <= quo[15:0];
        rcm_pkg::JOB_URY: q_ury <= quo[15:0];
        rcm_pkg::JOB_INC: inc <= (|quo[DW-1:32]) ? 32'hFFFF_FFFF : quo[31:0];
        rcm_pkg::JOB_AVG: avg <= quo[31:0];
        default:          avg <= quo[31:0];
      endcase
    end
    if (cmd.box) begin
      xl <= sx.lo;
      xu <= sx.hi;
      yl <= sy.lo;
      yu <= sy.hi;
    end
    if (cmd.mul1) begin
      wx <= xl;
      wy <= yl;
      w  <= rcm_pkg::SIDE_W'(rcm_pkg::SIDE_W'(xu - {1'b0, xl}) * rcm_pkg::SIDE_W'(bw));
      h  <= rcm_pkg::SIDE_W'(rcm_pkg::SIDE_W'(yu - {1'b0, yl}) * rcm_pkg::SIDE_W'(bh));
    end
    if (cmd.mul2) begin
      num <= {np, 8'd0};
      den <= (2 * rcm_pkg::SIDE_W)'(w) * (2 * rcm_pkg::SIDE_W)'(h);
    end
    if (cmd.walk_wr) begin
      // column-major walk, y fastest
      if (wy == GW'(yu - 1'b1)) begin
        wy <= yl;
        wx <= wx + 1'b1;
      end else begin
        wy <= wy + 1'b1;
      end
    end
    if (cmd.scan_rst) begin
      sum <= '0;
      mx  <= '0;
    end else if (rd_v) begin
      sum <= sum + rcm_pkg::SUM_W'(ram_rdata);
      if (ram_rdata > mx) mx <= ram_rdata;
    end
    if (cmd.cost) prod <= 64'(avg) * 64'(mx);
    if (cmd.fire) begin
      peak_util <= mx;
      mean_util <= avg;
      cost      <= (|prod[63:48]) ? 32'hFFFF_FFFF : prod[47:16];
    end
  end

endmodule

FILE: sv/routing_congestion_map_core.sv
// routing congestion map: 4 layers of 64 x 64 Q16.16 bins in one 16384-entry ram.
// after reset a clearing pass over all 16384 entries runs with busy high; an item is
// taken when start is high and busy low. clear keeps busy high while it clears them all.
// add net does five restoring divisions (four snaps and the increment) on the
// shared 48-bit divider, plus the box and product steps, then a read-modify-write
// of each covered bin on the single ram port. report reads layers*4096 bins, one a
// cycle, then drains, divides for the average and forms the cost. done pulses
// one cycle, in the same cycle as busy falls, with peak_util, mean_util and cost; the
// receiver cannot stall and must take them then. a net on a layer at or above the
// layer count and the unused opcode finish at once with no change.
module routing_congestion_map_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [1:0]  layer,
  input  logic [15:0] ll_x,
  input  logic [15:0] ll_y,
  input  logic [15:0] ur_x,
  input  logic [15:0] ur_y,
  input  logic [15:0] wire_weight,
  output logic        done,
  output logic [31:0] peak_util,
  output logic [31:0] mean_util,
  output logic [31:0] cost,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]   bin_width;
  logic [15:0]   bin_height;
  logic [2:0]    layers_in_use;
  logic          wr;
  rcm_pkg::cmd_t cmd;
  rcm_pkg::sts_t sts;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width     <= 16'd1;
      bin_height    <= 16'd1;
      layers_in_use <= 3'd1;
    end else if (wr) begin
      unique case (paddr[3:2])
        rcm_pkg::REG_BIN_W:  bin_width     <= pwdata[15:0];
        rcm_pkg::REG_BIN_H:  bin_height    <= pwdata[15:0];
        rcm_pkg::REG_LAYERS: layers_in_use <= pwdata[2:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rcm_pkg::REG_BIN_W:  prdata = {16'd0, bin_width};
      rcm_pkg::REG_BIN_H:  prdata = {16'd0, bin_height};
      rcm_pkg::REG_LAYERS: prdata = {29'd0, layers_in_use};
      default:             prdata = '0;
    endcase
  end

  rcm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rcm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .bin_width     (bin_width),
    .bin_height    (bin_height),
    .layers_in_use (layers_in_use),
    .opcode        (opcode),
    .layer         (layer),
    .ll_x          (ll_x),
    .ll_y          (ll_y),
    .ur_x          (ur_x),
    .ur_y          (ur_y),
    .wire_weight   (wire_weight),
    .done          (done),
    .peak_util     (peak_util),
    .mean_util     (mean_util),
    .cost          (cost)
  );

endmodule

FILE: tb/routing_congestion_map_core_tb.sv
`timescale 1ns / 100ps

module routing_congestion_map_core_tb;

  localparam int CYCLE_LIMIT = 200000000;
  localparam int BINS_PER_LAYER = rcm_pkg::GRID_DIM * rcm_pkg::GRID_DIM;

  typedef struct {
    logic [31:0] peak_util;
    logic [31:0] mean_util;
    logic [31:0] cost;
  } report_t;

  class congestion_scoreboard;
    logic [31:0] util_bins [rcm_pkg::MAX_LAYERS * BINS_PER_LAYER];
    logic [15:0] bin_w;
    logic [15:0] bin_h;
    logic [2:0]  layer_cnt;
    report_t     reports_due [$];

    function void reset_state();
      foreach (util_bins[i]) util_bins[i] = '0;
      bin_w = 16'd1;
      bin_h = 16'd1;
      layer_cnt = 3'd1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        rcm_pkg::REG_BIN_W:  bin_w = val[15:0];
        rcm_pkg::REG_BIN_H:  bin_h = val[15:0];
        rcm_pkg::REG_LAYERS: layer_cnt = val[2:0];
        default: ;
      endcase
    endfunction

    function int used_layers();
      int n;
      n = layer_cnt;
      if (n == 0) n = 1;
      if (n > rcm_pkg::MAX_LAYERS) n = rcm_pkg::MAX_LAYERS;
      return n;
    endfunction

    // outward snap to bins, upper index exclusive, never an empty span
    function void snap_span(longint unsigned lo, longint unsigned hi, longint unsigned sz,
                            output int lidx, output int uidx);
      longint unsigned l;
      longint unsigned u;
      l = lo / sz;
      u = hi / sz + 1;
      if (u > rcm_pkg::GRID_DIM) u = rcm_pkg::GRID_DIM;
      if (l > rcm_pkg::GRID_DIM - 1) l = rcm_pkg::GRID_DIM - 1;
      if (l >= u) l = u - 1;
      lidx = int'(l);
      uidx = int'(u);
    endfunction

    function void add_net(logic [1:0] ly, logic [15:0] llx, logic [15:0] lly,
                          logic [15:0] urx, logic [15:0] ury, logic [15:0] wt);
      longint unsigned bw;
      longint unsigned bh;
      longint unsigned w;
      longint unsigned h;
      longint unsigned inc;
      longint unsigned v;
      int xl, xu, yl, yu, idx;
      if (int'(ly) >= used_layers()) return;
      bw = (bin_w == 0) ? 1 : bin_w;
      bh = (bin_h == 0) ? 1 : bin_h;
      snap_span(llx, urx, bw, xl, xu);
      snap_span(lly, ury, bh, yl, yu);
      w = longint'(xu - xl) * bw;
      h = longint'(yu - yl) * bh;
      inc = (longint'(wt) * (w + h) * 256) / (w * h);
      if (inc > 64'hFFFF_FFFF) inc = 64'hFFFF_FFFF;
      for (int x = xl; x < xu; x++) begin
        for (int y = yl; y < yu; y++) begin
          idx = (int'(ly) * rcm_pkg::GRID_DIM + x) * rcm_pkg::GRID_DIM + y;
          v = longint'(util_bins[idx]) + inc;
          util_bins[idx] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        end
      end
    endfunction

    function report_t summarise();
      report_t r;
      longint unsigned sum;
      longint unsigned mx;
      longint unsigned avg;
      longint unsigned c;
      int count;
      count = used_layers() * BINS_PER_LAYER;
      sum = 0;
      mx = 0;
      for (int i = 0; i < count; i++) begin
        if (util_bins[i] > mx) mx = util_bins[i];
        sum += util_bins[i];
      end
      avg = sum / longint'(count);
      c = (avg * mx) >> 16;
      if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
      r.peak_util = mx[31:0];
      r.mean_util = avg[31:0];
      r.cost = c[31:0];
      return r;
    endfunction

    function void note_item(logic [1:0] op, logic [1:0] ly, logic [15:0] llx, logic [15:0] lly,
                            logic [15:0] urx, logic [15:0] ury, logic [15:0] wt);
      case (op)
        rcm_pkg::OP_CLEAR:  foreach (util_bins[i]) util_bins[i] = '0;
        rcm_pkg::OP_ADD:    add_net(ly, llx, lly, urx, ury, wt);
        rcm_pkg::OP_REPORT: reports_due.push_back(summarise());
        default: ;
      endcase
    endfunction

    // -1 when nothing was due, else a mask of the fields that differ
    function int check_report(logic [31:0] mx, logic [31:0] avg, logic [31:0] c,
                              output report_t due);
      int bad;
      if (reports_due.size() == 0) return -1;
      due = reports_due.pop_front();
      bad = 0;
      if (mx !== due.peak_util) bad |= 1;
      if (avg !== due.mean_util) bad |= 2;
      if (c !== due.cost) bad |= 4;
      return bad;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = '0;
  logic [1:0]  layer = '0;
  logic [15:0] ll_x = '0;
  logic [15:0] ll_y = '0;
  logic [15:0] ur_x = '0;
  logic [15:0] ur_y = '0;
  logic [15:0] wire_weight = '0;
  logic        done;
  logic [31:0] peak_util;
  logic [31:0] mean_util;
  logic [31:0] cost;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  routing_congestion_map_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .layer(layer),
    .ll_x(ll_x), .ll_y(ll_y), .ur_x(ur_x), .ur_y(ur_y), .wire_weight(wire_weight),
    .done(done), .peak_util(peak_util), .mean_util(mean_util), .cost(cost),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  congestion_scoreboard sb;
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    report_t due;
    int bad;
    if (!rst && done) begin
      bad = sb.check_report(peak_util, mean_util, cost, due);
      if (bad < 0) report_mismatch("report with none due, peak_util", peak_util, '0);
      else begin
        if (bad & 1) report_mismatch("peak_util", peak_util, due.peak_util);
        if (bad & 2) report_mismatch("mean_util", mean_util, due.mean_util);
        if (bad & 4) report_mismatch("cost", cost, due.cost);
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [1:0] ly, logic [15:0] llx, logic [15:0] lly,
                           logic [15:0] urx, logic [15:0] ury, logic [15:0] wt);
    start <= 1'b1;
    opcode <= op;
    layer <= ly;
    ll_x <= llx;
    ll_y <= lly;
    ur_x <= urx;
    ur_y <= ury;
    wire_weight <= wt;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, ly, llx, lly, urx, ury, wt);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // every report in, then let a trailing add or clear run out
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.reports_due.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_grid(logic [31:0] bw, logic [31:0] bh, logic [31:0] nl);
    wait_idle();
    write_reg(rcm_pkg::REG_BIN_W, bw);
    write_reg(rcm_pkg::REG_BIN_H, bh);
    write_reg(rcm_pkg::REG_LAYERS, nl);
  endtask

  function automatic logic [15:0] on_grid(int g, int sz);
    longint v;
    v = longint'(g) * sz + $urandom_range(0, sz - 1);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic random_item();
    int r, k, bw, bh, gx, gy;
    logic [15:0] a, b, c, d;
    r = $urandom_range(999);
    bw = (sb.bin_w == 0) ? 1 : sb.bin_w;
    bh = (sb.bin_h == 0) ? 1 : sb.bin_h;
    if (r < 5) send_item(rcm_pkg::OP_CLEAR, 2'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
    else if (r < 30) send_item(rcm_pkg::OP_REPORT, 2'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else if (r < 45) send_item(rcm_pkg::OP_UNUSED, 2'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else begin
      k = $urandom_range(9);
      gx = $urandom_range(0, 66);
      gy = $urandom_range(0, 66);
      if (k == 0) begin
        a = 16'($urandom); b = 16'($urandom); c = 16'($urandom); d = 16'($urandom);
      end else begin
        a = on_grid(gx, bw);
        b = on_grid(gy, bh);
        c = on_grid(gx + $urandom_range(0, 3), bw);
        d = on_grid(gy + $urandom_range(0, 3), bh);
        if (k == 1) begin
          // corners given the wrong way round
          {a, c} = {c, a};
          {b, d} = {d, b};
        end
      end
      send_item(rcm_pkg::OP_ADD, 2'($urandom), a, b, c, d, 16'($urandom));
    end
  endtask

  initial begin
    int pct [6];
    pct = '{0, 88, 0, 26, 88, 0};
    sb = new();
    sb.reset_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults are unit bins, one layer
    set_grid(1, 1, 1);
    send_item(rcm_pkg::OP_REPORT, 0, 0, 0, 0, 0, 0);
    send_item(rcm_pkg::OP_ADD, 0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(rcm_pkg::OP_REPORT, 0, 0, 0, 0, 0, 0);
    send_item(rcm_pkg::OP_ADD, 0, 16'd5, 16'd7, 16'd5, 16'd7, 16'h0000);
    send_item(rcm_pkg::OP_ADD, 0, 16'd9, 16'd9, 16'd3, 16'd2, 16'h0100);
    send_item(rcm_pkg::OP_ADD, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(rcm_pkg::OP_ADD, 2'd3, 16'd1, 16'd1, 16'd2, 16'd2, 16'h8000);
    send_item(rcm_pkg::OP_UNUSED, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(rcm_pkg::OP_REPORT, 0, 0, 0, 0, 0, 0);
    set_grid(0, 0, 7);
    send_item(rcm_pkg::OP_ADD, 2'd3, 16'd2, 16'd60, 16'd4, 16'd70, 16'h00FF);
    send_item(rcm_pkg::OP_ADD, 2'd2, 16'd70, 16'd1, 16'd62, 16'd1, 16'h1234);
    send_item(rcm_pkg::OP_REPORT, 0, 0, 0, 0, 0, 0);
    set_grid(16'hFFFF, 16'hFFFF, 0);
    send_item(rcm_pkg::OP_ADD, 0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_item(rcm_pkg::OP_REPORT, 0, 0, 0, 0, 0, 0);
    send_item(rcm_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_item(rcm_pkg::OP_REPORT, 0, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = 0;
      case (ph)
        0: set_grid(1, 1, 1);
        1: set_grid(16, 16, 4);
        2: set_grid(1024, 512, 2);
        3: set_grid(65535, 65535, 4);
        4: set_grid(3, 0, 3);
        default: set_grid($urandom_range(1, 2000), $urandom_range(1, 2000),
                          $urandom_range(1, 4));
      endcase
      idle_pct = pct[ph];
      for (int n = 0; n < 315; n++) begin
        random_item();
        if (ph == 2 && n == 150) begin
          start <= 1'b0;
          @(posedge clk);
          while (sb.reports_due.size() != 0) @(posedge clk);
        end
      end
      send_item(rcm_pkg::OP_REPORT, 0, 0, 0, 0, 0, 0);
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
